[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/brf_pkg.sv]
// ----------------------------------------------------------------------------
// brf_pkg
// Types and constants shared by the byte ring FIFO modules.
// ----------------------------------------------------------------------------
package brf_pkg;

    // field widths
    localparam int unsigned OP_W    = 3;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 11;
    localparam int unsigned INDEX_W = 10;

    // stream payload layout
    localparam int unsigned S_TDATA_W  = 24;
    localparam int unsigned S_TUSER_W  = OP_W;
    localparam int unsigned M_TDATA_W  = 80;
    localparam int unsigned M_PAD_W    = M_TDATA_W - (4 * COUNT_W + 2 * INDEX_W + BYTE_W + 2);
    localparam int unsigned S_PAD_W    = S_TDATA_W - (BYTE_W + COUNT_W);

    // register port
    localparam int unsigned PADDR_W    = 3;
    localparam int unsigned PDATA_W    = 32;
    localparam int unsigned REG_IDX_W  = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_RING_SIZE = '0;
    localparam int unsigned RING_SIZE_RST = 1024;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH        = 3'd0,
        OP_POP         = 3'd1,
        OP_ADVANCE_WR  = 3'd2,
        OP_ADVANCE_RD  = 3'd3,
        OP_RETREAT_WR  = 3'd4,
        OP_CLEAR       = 3'd5
    } op_t;

    typedef enum logic {
        S_IDLE   = 1'b0,
        S_RESULT = 1'b1
    } state_t;

    typedef struct packed {
        logic exec;     // request accepted, apply it this edge
    } ctl_cmd_t;

endpackage

[hdl/brf_ctrl.sv]
// ----------------------------------------------------------------------------
// brf_ctrl
// Handshake sequencer: accepts a request, holds the result until taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module brf_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output brf_pkg::ctl_cmd_t cmd
);

    brf_pkg::state_t state_reg;
    brf_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= brf_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            brf_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = brf_pkg::S_RESULT;
                end
            end
            brf_pkg::S_RESULT:
            begin
                if (m_tready && !s_tvalid)
                begin
                    state_next = brf_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = brf_pkg::S_IDLE;
            end
        endcase
    end

    // a new request may enter as the held result leaves
    always_comb
    begin
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        unique case (state_reg)
            brf_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
            end
            brf_pkg::S_RESULT:
            begin
                s_tready = m_tready;
                m_tvalid = 1'b1;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
        cmd.exec = s_tvalid && s_tready;
    end

    `ASSERT_NEXT(a_exec_gives_result, clk, rst_n, cmd.exec, m_tvalid, "accepted request gave no result")

endmodule

[hdl/brf_datapath.sv]
// ----------------------------------------------------------------------------
// brf_datapath
// Ring store, indices, fill level, size register and result formatting.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module brf_datapath
#(
    parameter int unsigned MAX_DEPTH = 1024
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  brf_pkg::ctl_cmd_t                 cmd,
    input  logic [brf_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic [brf_pkg::S_TUSER_W-1:0]     s_tuser,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [brf_pkg::PADDR_W-1:0]       paddr,
    input  logic [brf_pkg::PDATA_W-1:0]       pwdata,
    output logic [brf_pkg::PDATA_W-1:0]       prdata,
    output logic [brf_pkg::M_TDATA_W-1:0]     m_tdata
);

    localparam int unsigned PTR_W = $clog2(MAX_DEPTH);
    localparam int unsigned CNT_W = $clog2(MAX_DEPTH + 1);
    localparam int unsigned SUM_W =
        ((CNT_W > brf_pkg::COUNT_W) ? CNT_W : brf_pkg::COUNT_W) + 1;
    localparam int unsigned SIZE_RST =
        (brf_pkg::RING_SIZE_RST > MAX_DEPTH) ? MAX_DEPTH : brf_pkg::RING_SIZE_RST;

    logic [brf_pkg::BYTE_W-1:0]   ring_store [MAX_DEPTH];
    logic [brf_pkg::BYTE_W-1:0]   rd_byte_reg;

    logic [brf_pkg::COUNT_W-1:0]  ring_size_reg;
    logic [CNT_W-1:0]             size_eff_reg;
    logic [CNT_W-1:0]             size_eff_next;
    logic [PTR_W-1:0]             head_reg;
    logic [PTR_W-1:0]             head_next;
    logic [PTR_W-1:0]             tail_reg;
    logic [PTR_W-1:0]             tail_next;
    logic [CNT_W-1:0]             held_reg;
    logic [CNT_W-1:0]             held_next;
    logic [CNT_W-1:0]             moved_reg;
    logic [CNT_W-1:0]             moved_next;
    logic                         pop_ok_reg;
    logic                         pop_ok_next;
    logic                         push_en;

    brf_pkg::op_t                 op;
    logic [brf_pkg::BYTE_W-1:0]   write_byte;
    logic [brf_pkg::COUNT_W-1:0]  step_count;
    logic [brf_pkg::COUNT_W-1:0]  cfg_size;
    logic                         cfg_wr;

    logic [SUM_W-1:0] sz;
    logic [SUM_W-1:0] held;
    logic [SUM_W-1:0] head;
    logic [SUM_W-1:0] tail;
    logic [SUM_W-1:0] cnt;
    logic [SUM_W-1:0] free_bytes;
    logic [SUM_W-1:0] adv_wr;
    logic [SUM_W-1:0] adv_rd;
    logic [SUM_W-1:0] tail_sum;
    logic [SUM_W-1:0] head_sum;
    logic [SUM_W-1:0] tail_inc;
    logic [SUM_W-1:0] head_inc;
    logic [SUM_W-1:0] rd_room;
    logic [SUM_W-1:0] wr_room;
    logic [SUM_W-1:0] rd_span;
    logic [SUM_W-1:0] wr_span;

    assign op         = brf_pkg::op_t'(s_tuser);
    assign write_byte = s_tdata[brf_pkg::BYTE_W-1:0];
    assign step_count = s_tdata[brf_pkg::BYTE_W +: brf_pkg::COUNT_W];

    // register port
    assign cfg_wr   = psel && penable && pwrite &&
                      (paddr[brf_pkg::PADDR_W-1:2] == brf_pkg::REG_RING_SIZE);
    assign cfg_size = pwdata[brf_pkg::COUNT_W-1:0];

    always_comb
    begin
        if (paddr[brf_pkg::PADDR_W-1:2] == brf_pkg::REG_RING_SIZE)
        begin
            prdata = brf_pkg::PDATA_W'(ring_size_reg);
        end
        else
        begin
            prdata = '0;
        end
    end

    // zero acts as one, oversize acts as the store depth
    always_comb
    begin
        priority if (cfg_size == '0)
        begin
            size_eff_next = CNT_W'(1);
        end
        else if (SUM_W'(cfg_size) > SUM_W'(MAX_DEPTH))
        begin
            size_eff_next = CNT_W'(MAX_DEPTH);
        end
        else
        begin
            size_eff_next = CNT_W'(cfg_size);
        end
    end

    // operation arithmetic
    assign sz         = SUM_W'(size_eff_reg);
    assign held       = SUM_W'(held_reg);
    assign head       = SUM_W'(head_reg);
    assign tail       = SUM_W'(tail_reg);
    assign cnt        = SUM_W'(step_count);
    assign free_bytes = sz - held;
    assign adv_wr     = (cnt < free_bytes) ? cnt : free_bytes;
    assign adv_rd     = (cnt < held) ? cnt : held;
    assign tail_sum   = tail + adv_wr;
    assign head_sum   = head + adv_rd;
    assign tail_inc   = tail + SUM_W'(1);
    assign head_inc   = head + SUM_W'(1);

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        held_next   = held_reg;
        moved_next  = '0;
        pop_ok_next = 1'b0;
        push_en     = 1'b0;
        unique case (op)
            brf_pkg::OP_PUSH:
            begin
                if (held < sz)
                begin
                    push_en    = 1'b1;
                    tail_next  = (tail_inc >= sz) ? '0 : PTR_W'(tail_inc);
                    held_next  = CNT_W'(held + SUM_W'(1));
                    moved_next = CNT_W'(1);
                end
            end
            brf_pkg::OP_POP:
            begin
                if (held != '0)
                begin
                    pop_ok_next = 1'b1;
                    head_next   = (head_inc >= sz) ? '0 : PTR_W'(head_inc);
                    held_next   = CNT_W'(held - SUM_W'(1));
                    moved_next  = CNT_W'(1);
                end
            end
            brf_pkg::OP_ADVANCE_WR:
            begin
                tail_next  = (tail_sum >= sz) ? PTR_W'(tail_sum - sz) : PTR_W'(tail_sum);
                held_next  = CNT_W'(held + adv_wr);
                moved_next = CNT_W'(adv_wr);
            end
            brf_pkg::OP_ADVANCE_RD:
            begin
                head_next  = (head_sum >= sz) ? PTR_W'(head_sum - sz) : PTR_W'(head_sum);
                held_next  = CNT_W'(held - adv_rd);
                moved_next = CNT_W'(adv_rd);
            end
            brf_pkg::OP_RETREAT_WR:
            begin
                // ignored when empty
                if (held != '0)
                begin
                    tail_next  = (tail == '0) ? PTR_W'(sz - SUM_W'(1))
                                              : PTR_W'(tail - SUM_W'(1));
                    held_next  = CNT_W'(held - SUM_W'(1));
                    moved_next = CNT_W'(1);
                end
            end
            brf_pkg::OP_CLEAR:
            begin
                head_next = '0;
                tail_next = '0;
                held_next = '0;
            end
            default:
            begin
                moved_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_size_reg <= brf_pkg::COUNT_W'(brf_pkg::RING_SIZE_RST);
            size_eff_reg  <= CNT_W'(SIZE_RST);
            head_reg      <= '0;
            tail_reg      <= '0;
            held_reg      <= '0;
            moved_reg     <= '0;
            pop_ok_reg    <= 1'b0;
        end
        else if (cfg_wr)
        begin
            // a size change restarts the ring
            ring_size_reg <= cfg_size;
            size_eff_reg  <= size_eff_next;
            head_reg      <= '0;
            tail_reg      <= '0;
            held_reg      <= '0;
        end
        else if (cmd.exec)
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            held_reg   <= held_next;
            moved_reg  <= moved_next;
            pop_ok_reg <= pop_ok_next;
        end
    end

    // byte store: write at tail, read at head before the head moves
    always_ff @(posedge clk)
    begin
        if (cmd.exec && push_en)
        begin
            ring_store[tail_reg] <= write_byte;
        end
        if (cmd.exec)
        begin
            rd_byte_reg <= ring_store[head_reg];
        end
    end

    // result fields
    assign rd_room = sz - head;
    assign wr_room = sz - tail;
    assign rd_span = (rd_room < held) ? rd_room : held;
    assign wr_span = (wr_room < free_bytes) ? wr_room : free_bytes;

    assign m_tdata = {
        brf_pkg::M_PAD_W'(0),
        (held == sz),
        (held == '0),
        brf_pkg::COUNT_W'(wr_span),
        brf_pkg::COUNT_W'(rd_span),
        brf_pkg::INDEX_W'(tail_reg),
        brf_pkg::INDEX_W'(head_reg),
        brf_pkg::COUNT_W'(held_reg),
        (pop_ok_reg ? rd_byte_reg : brf_pkg::BYTE_W'(0)),
        brf_pkg::COUNT_W'(moved_reg)
    };

    `ASSERT_ALWAYS(a_fill_in_size, clk, rst_n, held_reg <= size_eff_reg, "fill level above ring size")
    `ASSERT_ALWAYS(a_head_in_size, clk, rst_n, SUM_W'(head_reg) < SUM_W'(size_eff_reg), "read index outside ring")
    `ASSERT_ALWAYS(a_tail_in_size, clk, rst_n, SUM_W'(tail_reg) < SUM_W'(size_eff_reg), "write index outside ring")

endmodule

[hdl/byte_ring_fifo.sv]
// Result is valid on m_tvalid in the cycle after a request is accepted.
// Throughput is one request per cycle while m_tready is high; a held result
// that is not taken drops s_tready until it leaves the output stage.
// Reset: indices and fill level zero, ring_size 1024 (effective size clamped to MAX_DEPTH);
// store contents are not cleared and stay undefined until pushed.
// ----------------------------------------------------------------------------
// byte_ring_fifo
// Byte ring buffer driven by one operation per request, with status result.
// ----------------------------------------------------------------------------
module byte_ring_fifo
#(
    parameter int unsigned MAX_DEPTH = 1024
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [7:0] write_byte, [18:8] step_count, [23:19] zero
    input  logic [brf_pkg::S_TDATA_W-1:0] s_tdata,
    // [2:0] operation
    input  logic [brf_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [10:0] moved_count, [18:11] read_byte, [29:19] fill_level,
    // [39:30] read_index, [49:40] write_index, [60:50] read_span,
    // [71:61] write_span, [72] is_empty, [73] is_full, [79:74] zero
    output logic [brf_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [brf_pkg::PADDR_W-1:0]   paddr,
    input  logic [brf_pkg::PDATA_W-1:0]   pwdata,
    output logic [brf_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    brf_pkg::ctl_cmd_t cmd;

    assign pready = 1'b1;

    brf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    brf_datapath
    #(
        .MAX_DEPTH (MAX_DEPTH)
    )
    u_datapath
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .m_tdata (m_tdata)
    );

endmodule
